FILE: rtl/core/mre_pkg.sv
// ----------------------------------------------------------------------------
// mre_pkg
// Shared types, codes and helpers of the mouse report encoder.
// ----------------------------------------------------------------------------
package mre_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 4;
  localparam int unsigned CFG_IDX_W       = 2;
  localparam int unsigned CFG_DATA_W      = 16;
  localparam int unsigned COORD_W         = 16;
  localparam int unsigned NUM_W           = 17;
  localparam int unsigned CODE_W          = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_TRACKING_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SGR_FORMAT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_ROWS    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_COLUMNS = 2'd3;

  localparam logic [1:0] TRK_DISABLED = 2'd0;
  localparam logic [1:0] TRK_NORMAL   = 2'd1;
  localparam logic [1:0] TRK_DRAG     = 2'd2;

  localparam logic [2:0] BTN_LEFT       = 3'd1;
  localparam logic [2:0] BTN_MIDDLE     = 3'd2;
  localparam logic [2:0] BTN_RIGHT      = 3'd3;
  localparam logic [2:0] BTN_WHEEL_UP   = 3'd4;
  localparam logic [2:0] BTN_WHEEL_DOWN = 3'd5;

  localparam logic [7:0] CH_ESC   = 8'h1b;
  localparam logic [7:0] CH_LBRK  = 8'h5b;
  localparam logic [7:0] CH_LT    = 8'h3c;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_UPM   = 8'h4d;
  localparam logic [7:0] CH_LOWM  = 8'h6d;
  localparam logic [7:0] LEG_OFS  = 8'h20;

  localparam logic [COORD_W-1:0] LEG_MAX_CELL = 16'd222;

  typedef struct packed {
    logic                sgr;
    logic                up_m;
    logic [CODE_W-1:0]   code;
    logic [NUM_W-1:0]    col1;
    logic [NUM_W-1:0]    row1;
    logic [2:0]          code_pos;
    logic [2:0]          col_pos;
    logic [2:0]          row_pos;
  } job_t;

  function automatic logic [NUM_W-1:0] pow10(input logic [2:0] p);
    logic [NUM_W-1:0] r;
    unique case (p)
      3'd0:    r = 17'd1;
      3'd1:    r = 17'd10;
      3'd2:    r = 17'd100;
      3'd3:    r = 17'd1000;
      3'd4:    r = 17'd10000;
      default: r = 17'd1;
    endcase
    return r;
  endfunction

  // index of the leading decimal digit
  function automatic logic [2:0] dig_pos(input logic [NUM_W-1:0] v);
    logic [2:0] n;
    n = 3'd0;
    for (int k = 1; k < 5; k++) begin
      if (v >= pow10(3'(k))) n = n + 3'd1;
    end
    return n;
  endfunction

endpackage

FILE: rtl/core/mouse_report_encoder_top.sv
// ----------------------------------------------------------------------------
// mouse_report_encoder_top
// Encodes mouse events into terminal mouse report byte streams.
// ----------------------------------------------------------------------------
// Input channel (in_*): one mouse event per request, accepted when in_valid
// is high and in_stall is low. in_stall rises only while the job queue of
// QUEUE_DEPTH entries is full; filtered events are taken and dropped.
// Output channel (out_*): one report byte per request, out_last marks the
// final byte. Bytes come from an output register; when out_stall is high the
// byte holds and the sequencer waits.
// Config channel (cfg_*): cfg_ready is always high; write only while idle.
// An accepted event is first written to the job queue, then the sequencer pops it.
// Throughput: while out_stall is low the sequencer sends one byte per cycle
// with no gap between reports; a report is 6 bytes in legacy form and up to
// 19 in SGR form.
// Each decimal digit is produced by the sequencer in its own cycle.
// Reset: synchronous, active low; clears the queue, the sequencer and all
// configuration registers (tracking disabled, legacy form, no clamping).
// ----------------------------------------------------------------------------
module mouse_report_encoder_top #(
  parameter int unsigned QUEUE_DEPTH = mre_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mre_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mre_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [2:0]                      in_button,
  input  logic                            in_pressed,
  input  logic                            in_motion,
  input  logic [2:0]                      in_modifier_keys,
  input  logic [mre_pkg::COORD_W-1:0]     in_row,
  input  logic [mre_pkg::COORD_W-1:0]     in_column,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      out_byte,
  output logic                            out_last
);
  import mre_pkg::*;

  logic q_full, q_push, q_valid, q_pop;
  job_t q_wdata, q_rdata;

  mre_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_button        (in_button),
    .in_pressed       (in_pressed),
    .in_motion        (in_motion),
    .in_modifier_keys (in_modifier_keys),
    .in_row           (in_row),
    .in_column        (in_column),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_wdata          (q_wdata)
  );

  mre_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .full      (q_full),
    .valid     (q_valid),
    .data      (q_rdata)
  );

  mre_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule

FILE: rtl/core/mre_front.sv
// ----------------------------------------------------------------------------
// mre_front
// Holds configuration, filters events, clamps cells and builds report jobs.
// ----------------------------------------------------------------------------
module mre_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mre_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mre_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [2:0]                      in_button,
  input  logic                            in_pressed,
  input  logic                            in_motion,
  input  logic [2:0]                      in_modifier_keys,
  input  logic [mre_pkg::COORD_W-1:0]     in_row,
  input  logic [mre_pkg::COORD_W-1:0]     in_column,
  input  logic                            q_full,
  output logic                            q_push,
  output mre_pkg::job_t                   q_wdata
);
  import mre_pkg::*;

  logic [1:0]         trk_mode_r, trk_mode_nxt;
  logic               sgr_r, sgr_nxt;
  logic [COORD_W-1:0] scr_rows_r, scr_rows_nxt;
  logic [COORD_W-1:0] scr_cols_r, scr_cols_nxt;

  logic               wheel, no_button, keep, far;
  logic [COORD_W-1:0] row_c, col_c;
  logic [CODE_W-1:0]  base, code;
  logic [NUM_W-1:0]   row1, col1;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;

  always_comb begin
    trk_mode_nxt = trk_mode_r;
    sgr_nxt      = sgr_r;
    scr_rows_nxt = scr_rows_r;
    scr_cols_nxt = scr_cols_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TRACKING_MODE:  trk_mode_nxt = cfg_wdata[1:0];
        CFG_SGR_FORMAT:     sgr_nxt      = cfg_wdata[0];
        CFG_SCREEN_ROWS:    scr_rows_nxt = cfg_wdata;
        CFG_SCREEN_COLUMNS: scr_cols_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trk_mode_r <= TRK_DISABLED;
      sgr_r      <= 1'b0;
      scr_rows_r <= '0;
      scr_cols_r <= '0;
    end else begin
      trk_mode_r <= trk_mode_nxt;
      sgr_r      <= sgr_nxt;
      scr_rows_r <= scr_rows_nxt;
      scr_cols_r <= scr_cols_nxt;
    end
  end

  always_comb begin
    wheel     = (in_button == BTN_WHEEL_UP) || (in_button == BTN_WHEEL_DOWN);
    no_button = !(wheel || (in_button == BTN_LEFT) || (in_button == BTN_MIDDLE) ||
                  (in_button == BTN_RIGHT));

    row_c = ((scr_rows_r != '0) && (in_row > scr_rows_r - 16'd1)) ?
            scr_rows_r - 16'd1 : in_row;
    col_c = ((scr_cols_r != '0) && (in_column > scr_cols_r - 16'd1)) ?
            scr_cols_r - 16'd1 : in_column;
    row1  = {1'b0, row_c} + 17'd1;
    col1  = {1'b0, col_c} + 17'd1;

    unique case (in_button)
      BTN_LEFT:       base = 7'd0;
      BTN_MIDDLE:     base = 7'd1;
      BTN_RIGHT:      base = 7'd2;
      BTN_WHEEL_UP:   base = 7'd64;
      BTN_WHEEL_DOWN: base = 7'd65;
      default:        base = 7'd3;
    endcase
    // legacy release loses the button identity
    if (!sgr_r && !in_pressed && !in_motion && !wheel) base = 7'd3;
    code = base | (in_motion ? 7'd32 : 7'd0) | {2'b00, in_modifier_keys, 2'b00};

    far  = !sgr_r && ((col_c > LEG_MAX_CELL) || (row_c > LEG_MAX_CELL));
    keep = (trk_mode_r != TRK_DISABLED) && !far &&
           !(in_motion && ((trk_mode_r == TRK_NORMAL) ||
                           ((trk_mode_r == TRK_DRAG) && no_button)));

    q_push           = in_valid && !q_full && keep;
    q_wdata.sgr      = sgr_r;
    q_wdata.up_m     = in_pressed || in_motion || wheel;
    q_wdata.code     = code;
    q_wdata.col1     = col1;
    q_wdata.row1     = row1;
    q_wdata.code_pos = dig_pos({10'd0, code});
    q_wdata.col_pos  = dig_pos(col1);
    q_wdata.row_pos  = dig_pos(row1);
  end

endmodule

FILE: rtl/core/mre_queue.sv
// ----------------------------------------------------------------------------
// mre_queue
// Small job FIFO between the front classifier and the byte sequencer.
// ----------------------------------------------------------------------------
module mre_queue #(
  parameter int unsigned DEPTH = mre_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  mre_pkg::job_t push_data,
  input  logic          pop,
  output logic          full,
  output logic          valid,
  output mre_pkg::job_t data
);
  import mre_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  job_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign valid   = (cnt_r != '0);
  assign data    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) cnt_nxt = cnt_r + CNT_W'(1);
    else if (do_pop && !do_push) cnt_nxt = cnt_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

FILE: rtl/core/mre_back.sv
// ----------------------------------------------------------------------------
// mre_back
// Byte sequencer: turns one job into the report bytes, one digit per cycle unless out_stall holds it.
// ----------------------------------------------------------------------------
module mre_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  mre_pkg::job_t q_data,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_byte,
  output logic          out_last
);
  import mre_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_HDR  = 6'b000010,
    ST_LEG  = 6'b000100,
    ST_NUM  = 6'b001000,
    ST_SEP  = 6'b010000,
    ST_TAIL = 6'b100000
  } state_t;

  typedef enum logic [1:0] {
    FLD_CODE = 2'd0,
    FLD_COL  = 2'd1,
    FLD_ROW  = 2'd2
  } fld_t;

  state_t           st_r, st_nxt;
  job_t             job_r, job_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  fld_t             fld_r, fld_nxt;
  logic [2:0]       pos_r, pos_nxt;
  logic [NUM_W-1:0] rem_r, rem_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_byte_r, out_byte_nxt;
  logic             out_last_r, out_last_nxt;

  logic             adv, emit, last_v;
  logic [7:0]       byte_v;
  logic [NUM_W-1:0] pw, sub;
  logic [3:0]       dig;

  assign adv       = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

  always_comb begin
    pw  = pow10(pos_r);
    dig = 4'd0;
    sub = '0;
    for (int k = 1; k < 10; k++) begin
      if (rem_r >= NUM_W'(k) * pw) begin
        dig = 4'(k);
        sub = NUM_W'(k) * pw;
      end
    end
  end

  always_comb begin
    st_nxt  = st_r;
    job_nxt = job_r;
    cnt_nxt = cnt_r;
    fld_nxt = fld_r;
    pos_nxt = pos_r;
    rem_nxt = rem_r;
    q_pop   = 1'b0;
    emit    = 1'b0;
    byte_v  = CH_ESC;
    last_v  = 1'b0;
    if (adv) begin
      unique case (st_r)
        ST_IDLE: begin
          if (q_valid) begin
            q_pop   = 1'b1;
            job_nxt = q_data;
            emit    = 1'b1;
            byte_v  = CH_ESC;
            cnt_nxt = 2'd0;
            st_nxt  = ST_HDR;
          end
        end
        ST_HDR: begin
          emit = 1'b1;
          if (cnt_r == 2'd0) begin
            byte_v  = CH_LBRK;
            cnt_nxt = 2'd1;
          end else if (job_r.sgr) begin
            byte_v  = CH_LT;
            fld_nxt = FLD_CODE;
            rem_nxt = {10'd0, job_r.code};
            pos_nxt = job_r.code_pos;
            st_nxt  = ST_NUM;
          end else begin
            byte_v  = CH_UPM;
            cnt_nxt = 2'd0;
            st_nxt  = ST_LEG;
          end
        end
        ST_LEG: begin
          emit    = 1'b1;
          cnt_nxt = cnt_r + 2'd1;
          unique case (cnt_r)
            2'd0:    byte_v = LEG_OFS + {1'b0, job_r.code};
            2'd1:    byte_v = LEG_OFS + job_r.col1[7:0];
            default: begin
              byte_v = LEG_OFS + job_r.row1[7:0];
              last_v = 1'b1;
              st_nxt = ST_IDLE;
            end
          endcase
        end
        ST_NUM: begin
          emit    = 1'b1;
          byte_v  = CH_ZERO + {4'd0, dig};
          rem_nxt = rem_r - sub;
          pos_nxt = pos_r - 3'd1;
          if (pos_r == 3'd0) st_nxt = (fld_r == FLD_ROW) ? ST_TAIL : ST_SEP;
        end
        ST_SEP: begin
          emit   = 1'b1;
          byte_v = CH_SEMI;
          st_nxt = ST_NUM;
          if (fld_r == FLD_CODE) begin
            fld_nxt = FLD_COL;
            rem_nxt = job_r.col1;
            pos_nxt = job_r.col_pos;
          end else begin
            fld_nxt = FLD_ROW;
            rem_nxt = job_r.row1;
            pos_nxt = job_r.row_pos;
          end
        end
        ST_TAIL: begin
          emit   = 1'b1;
          byte_v = job_r.up_m ? CH_UPM : CH_LOWM;
          last_v = 1'b1;
          st_nxt = ST_IDLE;
        end
        default: st_nxt = ST_IDLE;
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    if (adv) begin
      out_valid_nxt = emit;
      out_byte_nxt  = byte_v;
      out_last_nxt  = last_v;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      cnt_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r      <= job_nxt;
    fld_r      <= fld_nxt;
    pos_r      <= pos_nxt;
    rem_r      <= rem_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule
